### hw/rtl/lcr_pkg.sv
`timescale 1ns / 1ps

package lcr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_TARE    = 255;

  localparam int REQ_W      = 2;
  localparam int TARE_W     = 8;
  localparam int CNT_W      = 24;
  localparam int HALF_W     = 16;
  localparam int SETTLE_W   = 16;
  localparam int TOUT_W     = 24;
  localparam int GAP_W      = 24;
  localparam int GAIN_W     = 2;
  localparam int STATUS_W   = 2;
  localparam int VALUE_W    = SAMPLE_BITS + 1;
  localparam int BIT_W      = $clog2(SAMPLE_BITS + 4);
  localparam int SUM_W      = SAMPLE_BITS + TARE_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // request codes
  localparam logic [REQ_W-1:0] REQ_NONE     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ_BLK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ_NB  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_TARE     = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;

  // gain codes
  localparam logic [GAIN_W-1:0] GAIN_A128 = 2'd0;
  localparam logic [GAIN_W-1:0] GAIN_A64  = 2'd1;
  localparam logic [GAIN_W-1:0] GAIN_B32  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USEPIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 3'd5;

  localparam logic [GAIN_W-1:0]   RST_GAIN   = GAIN_A128;
  localparam logic [HALF_W-1:0]   RST_HALF   = 16'd100;
  localparam logic [SETTLE_W-1:0] RST_SETTLE = 16'd1000;
  localparam logic [TOUT_W-1:0]   RST_TOUT   = 24'd10000000;
  localparam logic [GAP_W-1:0]    RST_GAP    = 24'd5000000;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_WAIT   = 7'b0000010,
    S_SETTLE = 7'b0000100,
    S_HIGH   = 7'b0001000,
    S_LOW    = 7'b0010000,
    S_GAP    = 7'b0100000,
    S_DIV    = 7'b1000000
  } state_e;

  typedef enum logic {
    KIND_READ = 1'b0,
    KIND_TARE = 1'b1
  } kind_e;

  typedef struct packed {
    logic                tick;
    logic                cnt_clr;
    logic                cnt_inc;
    logic                bit_clr;
    logic                sample;
    logic                bit_inc;
    logic                tare_start;
    logic                tare_acc;
    logic                div_start;
    logic                offset_load;
    logic                res_valid;
    logic                val_en;
    logic [STATUS_W-1:0] res_status;
    logic                tare_done;
    logic                sck;
    logic                busy;
  } cmd_t;

  typedef struct packed {
    logic rdy;
    logic tare_zero;
    logic inc_ge_tout;
    logic cnt_ge_settle;
    logic inc_ge_half;
    logic last_bit;
    logic cnt_ge_gap;
    logic left_zero;
    logic quot_ok;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/lcr_if.sv
`timescale 1ns / 1ps

interface lcr_in_if import lcr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TARE_W-1:0] tare_count;
  logic              dout_level;
  logic              drdy_level;

  modport source (output valid, req_type, tare_count, dout_level, drdy_level, input ready);
  modport sink   (input valid, req_type, tare_count, dout_level, drdy_level, output ready);
endinterface

interface lcr_out_if import lcr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      sck_level;
  logic                      ready_now;
  logic                      result_valid;
  logic signed [VALUE_W-1:0] result_value;
  logic [STATUS_W-1:0]       result_status;
  logic                      tare_done;
  logic                      busy_res;

  modport source (output valid, sck_level, ready_now, result_valid, result_value,
                  result_status, tare_done, busy_res, input ready);
  modport sink   (input valid, sck_level, ready_now, result_valid, result_value,
                  result_status, tare_done, busy_res, output ready);
endinterface

interface lcr_cfg_if import lcr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/lcr_div.sv
`timescale 1ns / 1ps

// Signed sum / unsigned count, truncating toward zero. Restoring, one bit per cycle.
module lcr_div import lcr_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_W-1:0]       dividend_i,
  input  logic        [TARE_W-1:0]      divisor_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] quot_o
);

  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TARE_W-1:0] rem_q, rem_d;
  logic [TARE_W-1:0] dvs_q, dvs_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic              neg_q, neg_d;
  logic [TARE_W:0]   rem_sh;
  logic [TARE_W:0]   rem_sub;
  logic [SUM_W-1:0]  quo_neg;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    rem_sh  = {rem_q, quo_q[SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      neg_d  = dividend_i[SUM_W-1];
      quo_d  = dividend_i[SUM_W-1] ? ('0 - dividend_i) : dividend_i;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_d = rem_sub[TARE_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[TARE_W-1:0];
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
  end

  assign quo_neg = '0 - quo_q;
  assign done_o  = done_q;
  assign quot_o  = neg_q ? quo_neg[SAMPLE_BITS-1:0] : quo_q[SAMPLE_BITS-1:0];

endmodule

### hw/rtl/lcr_dpath.sv
`timescale 1ns / 1ps

module lcr_dpath import lcr_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_DATA_W-1:0]       cfg_data_i,
  input  logic [TARE_W-1:0]           tare_count_i,
  input  logic                        dout_level_i,
  input  logic                        drdy_level_i,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        sck_level_o,
  output logic                        ready_now_o,
  output logic                        result_valid_o,
  output logic signed [VALUE_W-1:0]   result_value_o,
  output logic [STATUS_W-1:0]         result_status_o,
  output logic                        tare_done_o,
  output logic                        busy_res_o
);

  localparam logic [TARE_W-1:0] TARE_MAX = TARE_W'(MAX_TARE);
  localparam logic [BIT_W-1:0]  DATA_BITS = BIT_W'(SAMPLE_BITS);

  // configuration
  logic [GAIN_W-1:0]   gain_q;
  logic [HALF_W-1:0]   half_q;
  logic [SETTLE_W-1:0] settle_q;
  logic [TOUT_W-1:0]   tout_q;
  logic                usepin_q;
  logic [GAP_W-1:0]    gap_q;

  logic [CNT_W-1:0]       cnt_q, cnt_d, cnt_inc;
  logic [BIT_W-1:0]       bit_q, bit_d, bit_nxt;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic signed [SAMPLE_BITS-1:0] offset_q, offset_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [TARE_W-1:0]      left_q, left_d;
  logic [TARE_W-1:0]      total_q, total_d;
  logic signed [SAMPLE_BITS-1:0] quot_q, div_quot;
  logic                   quot_ok_q, quot_ok_d;
  logic                   div_done;

  logic                   out_vld_q, out_vld_d;
  logic                   o_sck_q, o_rdy_q, o_val_q, o_tdone_q, o_busy_q;
  logic signed [VALUE_W-1:0] o_value_q;
  logic [STATUS_W-1:0]    o_status_q;

  logic                   cfg_we;
  logic                   rdy;
  logic [HALF_W-1:0]      half_eff;
  logic [BIT_W-1:0]       pulses;
  logic [TARE_W-1:0]      tare_n;
  logic signed [VALUE_W-1:0] value;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= RST_GAIN;
      half_q   <= RST_HALF;
      settle_q <= RST_SETTLE;
      tout_q   <= RST_TOUT;
      usepin_q <= 1'b0;
      gap_q    <= RST_GAP;
    end else if (cfg_we) begin
      case (cfg_index_i)
        CFG_GAIN:   gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_HALF:   half_q   <= cfg_data_i[HALF_W-1:0];
        CFG_SETTLE: settle_q <= cfg_data_i[SETTLE_W-1:0];
        CFG_TOUT:   tout_q   <= cfg_data_i[TOUT_W-1:0];
        CFG_USEPIN: usepin_q <= cfg_data_i[0];
        CFG_GAP:    gap_q    <= cfg_data_i[GAP_W-1:0];
        default:    ;
      endcase
    end
  end

  // status toward the controller
  always_comb begin
    rdy      = usepin_q ? !drdy_level_i : !dout_level_i;
    cnt_inc  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
    half_eff = (half_q == '0) ? HALF_W'(1) : half_q;
    bit_nxt  = bit_q + 1'b1;
    case (gain_q)
      GAIN_A64: pulses = BIT_W'(3);
      GAIN_B32: pulses = BIT_W'(2);
      default:  pulses = BIT_W'(1);
    endcase
    tare_n = (tare_count_i > TARE_MAX) ? TARE_MAX : tare_count_i;

    sts_o.rdy           = rdy;
    sts_o.tare_zero     = (tare_n == '0);
    sts_o.inc_ge_tout   = (cnt_inc >= tout_q);
    sts_o.cnt_ge_settle = (cnt_q >= CNT_W'(settle_q));
    sts_o.inc_ge_half   = (cnt_inc >= CNT_W'(half_eff));
    sts_o.last_bit      = (bit_nxt >= DATA_BITS + pulses);
    sts_o.cnt_ge_gap    = (cnt_q >= gap_q);
    sts_o.left_zero     = (left_q == '0);
    sts_o.quot_ok       = quot_ok_q;
    sts_o.div_done      = div_done;
    sts_o.out_free      = !out_vld_q || out_ready_i;

    value = {shift_q[SAMPLE_BITS-1], shift_q} - {offset_q[SAMPLE_BITS-1], offset_q};
  end

  always_comb begin
    cnt_d     = cnt_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    offset_d  = offset_q;
    sum_d     = sum_q;
    left_d    = left_q;
    total_d   = total_q;
    quot_ok_d = quot_ok_q;
    out_vld_d = out_vld_q;

    if (out_ready_i) out_vld_d = 1'b0;
    if (div_done) quot_ok_d = 1'b1;

    if (cmd_i.tick) begin
      out_vld_d = 1'b1;
      if (cmd_i.cnt_clr) cnt_d = '0;
      else if (cmd_i.cnt_inc) cnt_d = cnt_inc;
      if (cmd_i.bit_clr) begin
        bit_d   = '0;
        shift_d = '0;
      end else begin
        if (cmd_i.bit_inc) bit_d = bit_nxt;
        if (cmd_i.sample && (bit_q < DATA_BITS)) begin
          shift_d = {shift_q[SAMPLE_BITS-2:0], dout_level_i};
        end
      end
      if (cmd_i.tare_start) begin
        left_d    = tare_n;
        total_d   = tare_n;
        sum_d     = '0;
        quot_ok_d = 1'b0;
      end else if (cmd_i.tare_acc) begin
        sum_d = sum_q + {{TARE_W{shift_q[SAMPLE_BITS-1]}}, shift_q};
        if (left_q != '0) left_d = left_q - 1'b1;
      end
      if (cmd_i.offset_load) offset_d = quot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      bit_q     <= '0;
      offset_q  <= '0;
      left_q    <= '0;
      total_q   <= '0;
      quot_ok_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      bit_q     <= bit_d;
      offset_q  <= offset_d;
      left_q    <= left_d;
      total_q   <= total_d;
      quot_ok_q <= quot_ok_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    sum_q   <= sum_d;
    if (div_done) quot_q <= div_quot;
    if (cmd_i.tick) begin
      o_sck_q    <= cmd_i.sck;
      o_rdy_q    <= rdy;
      o_val_q    <= cmd_i.res_valid;
      o_value_q  <= cmd_i.val_en ? value : '0;
      o_status_q <= cmd_i.res_status;
      o_tdone_q  <= cmd_i.tare_done;
      o_busy_q   <= cmd_i.busy;
    end
  end

  lcr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (total_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_valid_o     = out_vld_q;
  assign sck_level_o     = o_sck_q;
  assign ready_now_o     = o_rdy_q;
  assign result_valid_o  = o_val_q;
  assign result_value_o  = o_value_q;
  assign result_status_o = o_status_q;
  assign tare_done_o     = o_tdone_q;
  assign busy_res_o      = o_busy_q;

endmodule

### hw/rtl/lcr_ctrl.sv
`timescale 1ns / 1ps

module lcr_ctrl import lcr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [REQ_W-1:0] req_type_i,
  input  sts_t             sts_i,
  output cmd_t             cmd_o
);

  state_e state_q, state_d, ph;
  kind_e  kind_q, kind_d;
  logic   stall_div;
  logic   tick;

  // last tick of a tare needs the average; run the divider first
  assign stall_div = (state_q == S_GAP) && sts_i.cnt_ge_gap && sts_i.left_zero &&
                     !sts_i.quot_ok;
  assign in_ready_o = sts_i.out_free && (state_q != S_DIV) && !stall_div;
  assign tick       = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o      = '0;
    cmd_o.tick = tick;
    state_d    = state_q;
    kind_d     = kind_q;
    ph         = state_q;

    if (state_q == S_DIV) begin
      if (sts_i.div_done) state_d = S_GAP;
    end else if (stall_div) begin
      cmd_o.div_start = 1'b1;
      state_d         = S_DIV;
    end else if (tick) begin
      if (state_q == S_IDLE) begin
        case (req_type_i)
          REQ_READ_BLK: begin
            kind_d = KIND_READ;
            ph     = S_WAIT;
          end
          REQ_READ_NB: begin
            if (!sts_i.rdy) begin
              cmd_o.res_valid  = 1'b1;
              cmd_o.res_status = ST_NOT_READY;
            end else begin
              kind_d = KIND_READ;
              ph     = S_SETTLE;
            end
          end
          REQ_TARE: begin
            if (sts_i.tare_zero) begin
              cmd_o.tare_done = 1'b1;
            end else begin
              kind_d           = KIND_TARE;
              cmd_o.tare_start = 1'b1;
              ph               = S_WAIT;
            end
          end
          default: ;
        endcase
      end

      // a request taken this tick is already worked on in its first phase
      state_d = ph;
      case (ph)
        S_WAIT: begin
          if (sts_i.rdy) begin
            state_d       = S_SETTLE;
            cmd_o.cnt_clr = 1'b1;
          end else if (sts_i.inc_ge_tout) begin
            state_d          = S_IDLE;
            cmd_o.cnt_clr    = 1'b1;
            cmd_o.res_status = ST_TIMEOUT;
            if (kind_d == KIND_TARE) cmd_o.tare_done = 1'b1;
            else cmd_o.res_valid = 1'b1;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
        S_SETTLE: begin
          if (sts_i.cnt_ge_settle) begin
            state_d       = S_HIGH;
            cmd_o.cnt_clr = 1'b1;
            cmd_o.bit_clr = 1'b1;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
        S_HIGH: begin
          if (sts_i.inc_ge_half) begin
            state_d       = S_LOW;
            cmd_o.cnt_clr = 1'b1;
            cmd_o.sample  = 1'b1;
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
        S_LOW: begin
          if (sts_i.inc_ge_half) begin
            cmd_o.cnt_clr = 1'b1;
            cmd_o.bit_inc = 1'b1;
            if (sts_i.last_bit) begin
              if (kind_d == KIND_READ) begin
                state_d         = S_IDLE;
                cmd_o.res_valid = 1'b1;
                cmd_o.val_en    = 1'b1;
              end else begin
                state_d        = S_GAP;
                cmd_o.tare_acc = 1'b1;
              end
            end else begin
              state_d = S_HIGH;
            end
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
        S_GAP: begin
          if (sts_i.cnt_ge_gap) begin
            cmd_o.cnt_clr = 1'b1;
            if (sts_i.left_zero) begin
              state_d           = S_IDLE;
              cmd_o.offset_load = 1'b1;
              cmd_o.tare_done   = 1'b1;
            end else begin
              state_d = S_WAIT;
            end
          end else begin
            cmd_o.cnt_inc = 1'b1;
          end
        end
        default: ;
      endcase
      cmd_o.sck  = (state_d == S_HIGH);
      cmd_o.busy = (state_d != S_IDLE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= KIND_READ;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

`ifndef SYNTHESIS
  a_div_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == S_DIV)
    else $error("divider start did not enter the divide state");

  a_div_leave: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_GAP && sts_i.quot_ok))
    else $error("divide state left without a quotient");

  a_offset_has_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.offset_load |-> sts_i.quot_ok)
    else $error("offset loaded before the average was ready");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |-> sts_i.out_free)
    else $error("tick taken while a result is still pending");

  a_acc_is_tare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.tare_acc |-> (kind_q == KIND_TARE && state_q == S_LOW))
    else $error("tare accumulate outside a tare reading");
`endif

endmodule

### hw/rtl/load_cell_adc_serial_reader.sv
`timescale 1ns / 1ps

// Tick-driven master for a two-wire 24-bit load-cell converter. Every input
// transaction is one time tick carrying sampled pin levels and an optional
// request; every tick yields exactly one result transaction with the serial
// clock level to drive, readiness, and any read or tare completion. A tick is
// normally taken each clock cycle, held off only while the previous result is
// still waiting at the output register. The one exception is the last tick of
// a tare: before it is taken, the average of the summed readings is computed
// by a restoring divider that produces one quotient bit per cycle, and that
// tick waits until the divider is done. Configuration writes are accepted
// in every cycle and should only be issued while the block is idle.
module load_cell_adc_serial_reader import lcr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  lcr_cfg_if.sink        cfg_i,
  lcr_in_if.sink         in_i,
  lcr_out_if.source      out_o
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready = in_ready;

  lcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .req_type_i (in_i.req_type),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcr_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_i.valid),
    .cfg_ready_o     (cfg_i.ready),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .tare_count_i    (in_i.tare_count),
    .dout_level_i    (in_i.dout_level),
    .drdy_level_i    (in_i.drdy_level),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .sck_level_o     (out_o.sck_level),
    .ready_now_o     (out_o.ready_now),
    .result_valid_o  (out_o.result_valid),
    .result_value_o  (out_o.result_value),
    .result_status_o (out_o.result_status),
    .tare_done_o     (out_o.tare_done),
    .busy_res_o      (out_o.busy_res)
  );

endmodule
